[rtl/tcp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types, screen geometry and helpers of the text console with pointer.
// ----------------------------------------------------------------------------
package tcp_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned IDX_W   = $clog2(CELLS);

  localparam int unsigned COL_W = 7;
  localparam int unsigned ROW_W = 5;

  localparam int unsigned PTR_COL_HOME = (40 > COLUMNS - 1) ? COLUMNS - 1 : 40;
  localparam int unsigned PTR_ROW_HOME = (12 > ROWS - 1) ? ROWS - 1 : 12;

  localparam logic [7:0] ATTR_BLANK   = 8'h07;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  function automatic idx_t cell_idx(input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col);
    cell_idx = idx_t'(row * COLUMNS + col);
  endfunction

  // swap the two colour nibbles of an attribute
  function automatic logic [7:0] swap_attr(input logic [7:0] a);
    swap_attr = {a[3:0], a[7:4]};
  endfunction

endpackage
`default_nettype wire

[rtl/tcp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_if
// Valid/ready channels of the console: command input and status output.
// ----------------------------------------------------------------------------
interface tcp_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [7:0]               char_code;
  logic signed [7:0]        move_dx;
  logic signed [7:0]        move_dy;
  logic [10:0]              read_index;

  modport source (output valid, cmd, char_code, move_dx, move_dy, read_index,
                  input ready);
  modport sink   (input valid, cmd, char_code, move_dx, move_dy, read_index,
                  output ready);
endinterface

interface tcp_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_line;
  logic [6:0]  pointer_column;
  logic [4:0]  pointer_line;
  logic [15:0] cell_data;
  logic        screen_cleared;

  modport source (output valid, cursor_column, cursor_line, pointer_column,
                  pointer_line, cell_data, screen_cleared, input ready);
  modport sink   (input valid, cursor_column, cursor_line, pointer_column,
                  pointer_line, cell_data, screen_cleared, output ready);
endinterface
`default_nettype wire

[rtl/tcp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

[rtl/text_console_with_pointer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_with_pointer
// 80x25 text cell store with a wrapping text cursor and an inverted pointer.
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one command per transaction (write char, pointer move, read
//   cell); out_o returns one status transaction per command with both
//   positions, the read cell and the screen-cleared flag.
//   cells live in two single-port RAMs: attribute bytes and character bytes.
//   after reset a fill pass writes the blank screen and the inverted
//   pointer cell; in_i.ready stays low during it. a pointer move runs
//   read, swap back, read, swap of the new cell; a read takes the cell
//   from the registered RAM output. in_i.ready returns in the cycle that
//   the result is loaded into the output register. a write that runs off
//   the last row sweeps the character RAM one cell per cycle.
//   one command is in flight at a time; a finished result sits in the output
//   register so the next command is taken while out_o is stalled, but that
//   command's result waits until the previous one is taken.
// ----------------------------------------------------------------------------
module text_console_with_pointer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcp_in_if.sink     in_i,
  tcp_out_if.source  out_o
);

  typedef enum logic [7:0] {
    ST_INIT    = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_CLEAR   = 8'b0000_0100,
    ST_PTR_OLD = 8'b0000_1000,
    ST_PTR_RD  = 8'b0001_0000,
    ST_PTR_NEW = 8'b0010_0000,
    ST_RD      = 8'b0100_0000,
    ST_RESP    = 8'b1000_0000
  } state_e;

  localparam tcp_pkg::idx_t LastIdx = tcp_pkg::idx_t'(tcp_pkg::CELLS - 1);
  localparam tcp_pkg::idx_t PtrHomeIdx =
      tcp_pkg::idx_t'(tcp_pkg::PTR_ROW_HOME * tcp_pkg::COLUMNS + tcp_pkg::PTR_COL_HOME);

  state_e state_q, state_d;
  tcp_pkg::idx_t ctr_q, ctr_d;
  logic [tcp_pkg::COL_W-1:0] text_col_q, text_col_d, ptr_col_q, ptr_col_d;
  logic [tcp_pkg::ROW_W-1:0] text_row_q, text_row_d, ptr_row_q, ptr_row_d;
  logic signed [7:0] dx_q, dx_d, dy_q, dy_d;
  logic in_range_q, in_range_d;
  logic cleared_q, cleared_d;
  logic [15:0] cell_q, cell_d;
  logic out_valid_q, out_valid_d;
  logic [tcp_pkg::COL_W-1:0] out_ccol_q, out_ccol_d, out_pcol_q, out_pcol_d;
  logic [tcp_pkg::ROW_W-1:0] out_crow_q, out_crow_d, out_prow_q, out_prow_d;
  logic [15:0] out_cell_q, out_cell_d;
  logic out_clr_q, out_clr_d;

  logic          in_fire, out_free;
  tcp_pkg::idx_t cur_idx, ptr_idx, ram_addr;
  logic          attr_we, char_we;
  logic [7:0]    attr_wdata, char_wdata, attr_rdata, char_rdata;
  logic [tcp_pkg::COL_W:0] col_inc;
  logic [tcp_pkg::ROW_W:0] row_inc;
  logic signed [9:0] col_sum, row_sum;

  tcp_ram #(.WIDTH(8), .DEPTH(tcp_pkg::CELLS)) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (attr_we),
    .addr_i  (ram_addr),
    .wdata_i (attr_wdata),
    .rdata_o (attr_rdata)
  );

  tcp_ram #(.WIDTH(8), .DEPTH(tcp_pkg::CELLS)) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (char_we),
    .addr_i  (ram_addr),
    .wdata_i (char_wdata),
    .rdata_o (char_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign cur_idx = tcp_pkg::cell_idx(text_row_q, text_col_q);
  assign ptr_idx = tcp_pkg::cell_idx(ptr_row_q, ptr_col_q);

  assign col_inc = {1'b0, text_col_q} + 1'b1;
  assign row_inc = {1'b0, text_row_q} + 1'b1;
  assign col_sum = $signed({3'b000, ptr_col_q}) + 10'(dx_q);
  assign row_sum = $signed({5'b00000, ptr_row_q}) + 10'(dy_q);

  always_comb begin
    state_d     = state_q;
    ctr_d       = ctr_q;
    text_col_d  = text_col_q;
    text_row_d  = text_row_q;
    ptr_col_d   = ptr_col_q;
    ptr_row_d   = ptr_row_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    in_range_d  = in_range_q;
    cleared_d   = cleared_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_ccol_d  = out_ccol_q;
    out_crow_d  = out_crow_q;
    out_pcol_d  = out_pcol_q;
    out_prow_d  = out_prow_q;
    out_cell_d  = out_cell_q;
    out_clr_d   = out_clr_q;
    ram_addr    = cur_idx;
    attr_we     = 1'b0;
    char_we     = 1'b0;
    attr_wdata  = tcp_pkg::swap_attr(attr_rdata);
    char_wdata  = in_i.char_code;

    unique case (state_q)
      ST_INIT: begin
        ram_addr   = ctr_q;
        attr_we    = 1'b1;
        char_we    = 1'b1;
        attr_wdata = (ctr_q == PtrHomeIdx) ? tcp_pkg::swap_attr(tcp_pkg::ATTR_BLANK)
                                           : tcp_pkg::ATTR_BLANK;
        char_wdata = tcp_pkg::CHAR_SPACE;
        ctr_d      = ctr_q + 1'b1;
        if (ctr_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          cleared_d = 1'b0;
          cell_d    = '0;
          dx_d      = in_i.move_dx;
          dy_d      = in_i.move_dy;
          unique case (tcp_pkg::cmd_e'(in_i.cmd))
            tcp_pkg::CMD_WRITE: begin
              if (in_i.char_code != tcp_pkg::CHAR_NEWLINE) begin
                char_we = 1'b1;
              end
              if (in_i.char_code == tcp_pkg::CHAR_NEWLINE ||
                  col_inc == (tcp_pkg::COL_W + 1)'(tcp_pkg::COLUMNS)) begin
                text_col_d = '0;
                if (row_inc == (tcp_pkg::ROW_W + 1)'(tcp_pkg::ROWS)) begin
                  text_row_d = '0;
                  cleared_d  = 1'b1;
                  ctr_d      = '0;
                  state_d    = ST_CLEAR;
                end else begin
                  text_row_d = row_inc[tcp_pkg::ROW_W-1:0];
                  state_d    = ST_RESP;
                end
              end else begin
                text_col_d = col_inc[tcp_pkg::COL_W-1:0];
                state_d    = ST_RESP;
              end
            end
            tcp_pkg::CMD_MOVE: begin
              ram_addr = ptr_idx;
              state_d  = ST_PTR_OLD;
            end
            tcp_pkg::CMD_READ: begin
              ram_addr   = tcp_pkg::idx_t'(in_i.read_index);
              in_range_d = (32'(in_i.read_index) < tcp_pkg::CELLS);
              state_d    = ST_RD;
            end
            tcp_pkg::CMD_NONE: begin
              state_d = ST_RESP;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_CLEAR: begin
        // attributes stay, every character becomes a space
        ram_addr   = ctr_q;
        char_we    = 1'b1;
        char_wdata = tcp_pkg::CHAR_SPACE;
        ctr_d      = ctr_q + 1'b1;
        if (ctr_q == LastIdx) begin
          state_d = ST_RESP;
        end
      end
      ST_PTR_OLD: begin
        // restore old pointer cell, then clamp the new position
        ram_addr = ptr_idx;
        attr_we  = 1'b1;
        if (col_sum < 0) begin
          ptr_col_d = '0;
        end else if (col_sum > 10'(tcp_pkg::COLUMNS - 1)) begin
          ptr_col_d = tcp_pkg::COL_W'(tcp_pkg::COLUMNS - 1);
        end else begin
          ptr_col_d = col_sum[tcp_pkg::COL_W-1:0];
        end
        if (row_sum < 0) begin
          ptr_row_d = '0;
        end else if (row_sum > 10'(tcp_pkg::ROWS - 1)) begin
          ptr_row_d = tcp_pkg::ROW_W'(tcp_pkg::ROWS - 1);
        end else begin
          ptr_row_d = row_sum[tcp_pkg::ROW_W-1:0];
        end
        state_d = ST_PTR_RD;
      end
      ST_PTR_RD: begin
        ram_addr = ptr_idx;
        state_d  = ST_PTR_NEW;
      end
      ST_PTR_NEW: begin
        ram_addr = ptr_idx;
        attr_we  = 1'b1;
        state_d  = ST_RESP;
      end
      ST_RD: begin
        cell_d  = in_range_q ? {attr_rdata, char_rdata} : 16'h0000;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ccol_d  = text_col_q;
          out_crow_d  = text_row_q;
          out_pcol_d  = ptr_col_q;
          out_prow_d  = ptr_row_q;
          out_cell_d  = cell_q;
          out_clr_d   = cleared_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ctr_q       <= '0;
      text_col_q  <= '0;
      text_row_q  <= '0;
      ptr_col_q   <= tcp_pkg::COL_W'(tcp_pkg::PTR_COL_HOME);
      ptr_row_q   <= tcp_pkg::ROW_W'(tcp_pkg::PTR_ROW_HOME);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      text_col_q  <= text_col_d;
      text_row_q  <= text_row_d;
      ptr_col_q   <= ptr_col_d;
      ptr_row_q   <= ptr_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    in_range_q <= in_range_d;
    cleared_q  <= cleared_d;
    cell_q     <= cell_d;
    out_ccol_q <= out_ccol_d;
    out_crow_q <= out_crow_d;
    out_pcol_q <= out_pcol_d;
    out_prow_q <= out_prow_d;
    out_cell_q <= out_cell_d;
    out_clr_q  <= out_clr_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.cursor_column  = out_ccol_q;
  assign out_o.cursor_line    = out_crow_q;
  assign out_o.pointer_column = out_pcol_q;
  assign out_o.pointer_line   = out_prow_q;
  assign out_o.cell_data      = out_cell_q;
  assign out_o.screen_cleared = out_clr_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("command accepted while another is in flight");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(text_col_q) < tcp_pkg::COLUMNS) && (32'(text_row_q) < tcp_pkg::ROWS))
    else $error("text cursor off screen");

  a_pointer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(ptr_col_q) < tcp_pkg::COLUMNS) && (32'(ptr_row_q) < tcp_pkg::ROWS))
    else $error("pointer off screen");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && !out_o.ready)) |-> $past(state_q == ST_RESP))
    else $error("result loaded outside the response state");

  a_clear_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> cleared_q && (text_col_q == '0) && (text_row_q == '0))
    else $error("screen sweep without homed cursor");

endmodule
`default_nettype wire

[tb/tb_text_console_with_pointer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_with_pointer
// Runs write, pointer-move, read and unused commands into the console. A
// local screen predictor works out each status transaction, and the
// monitor compares the returned status against it. Both channels idle
// at random, and the run includes a long output stall and two full
// drains.
// ----------------------------------------------------------------------------
module tb_text_console_with_pointer;
  import tcp_pkg::*;

  typedef struct {
    cmd_e              cmd;
    logic [7:0]        char_code;
    logic signed [7:0] move_dx;
    logic signed [7:0] move_dy;
    logic [10:0]       read_index;
    bit                drain;
  } console_cmd_t;

  typedef struct packed {
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic [6:0]  ptr_col;
    logic [4:0]  ptr_row;
    logic [15:0] cell_word;
    logic        cleared;
  } console_status_t;

  logic clk_i;
  logic rst_ni;

  tcp_in_if  in_if ();
  tcp_out_if out_if ();

  text_console_with_pointer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // predicted screen and positions
  logic [15:0] screen [CELLS];
  int unsigned txt_col;
  int unsigned txt_row;
  int unsigned ptr_x;
  int unsigned ptr_y;

  console_cmd_t    cmd_q [$];
  console_status_t status_q [$];
  console_cmd_t    cur_cmd;

  int   gap_cnt = 0;
  int   stall_cnt = 0;
  int   n_total = 0;
  int   n_accepted = 0;
  int   n_results = 0;
  int   n_errors = 0;
  int   gen_px = PTR_COL_HOME;
  int   gen_py = PTR_ROW_HOME;
  bit   drain_next = 1'b0;
  logic quiet_tail = 1'b0;
  logic hold_out = 1'b0;
  logic [15:0] cyc = '0;

  function automatic int fit(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void invert_cell(input int unsigned idx);
    screen[idx] = {screen[idx][11:8], screen[idx][15:12], screen[idx][7:0]};
  endfunction

  function automatic console_status_t console_apply(input console_cmd_t c);
    console_status_t s;
    int i;
    s.cell_word = '0;
    s.cleared   = 1'b0;
    case (c.cmd)
      CMD_WRITE: begin
        if (c.char_code == CHAR_NEWLINE) begin
          txt_row++;
          txt_col = 0;
        end else begin
          screen[txt_row * COLUMNS + txt_col][7:0] = c.char_code;
          txt_col++;
        end
        if (txt_col >= COLUMNS) begin
          txt_row++;
          txt_col = 0;
        end
        // ran off the last row: blank characters, keep attributes
        if (txt_row >= ROWS) begin
          for (i = 0; i < CELLS; i++) screen[i][7:0] = CHAR_SPACE;
          txt_row   = 0;
          txt_col   = 0;
          s.cleared = 1'b1;
        end
      end
      CMD_MOVE: begin
        invert_cell(ptr_y * COLUMNS + ptr_x);
        ptr_x = fit(int'(ptr_x) + int'(c.move_dx), COLUMNS - 1);
        ptr_y = fit(int'(ptr_y) + int'(c.move_dy), ROWS - 1);
        invert_cell(ptr_y * COLUMNS + ptr_x);
      end
      CMD_READ: begin
        if (c.read_index < CELLS) s.cell_word = screen[c.read_index];
      end
      default: ;
    endcase
    s.cur_col = 7'(txt_col);
    s.cur_row = 5'(txt_row);
    s.ptr_col = 7'(ptr_x);
    s.ptr_row = 5'(ptr_y);
    return s;
  endfunction

  task automatic queue_cmd(input cmd_e op, input int arg_a, input int arg_b);
    console_cmd_t c;
    c.cmd        = op;
    c.char_code  = 8'($urandom);
    c.move_dx    = 8'($urandom);
    c.move_dy    = 8'($urandom);
    c.read_index = 11'($urandom);
    c.drain      = drain_next;
    drain_next   = 1'b0;
    case (op)
      CMD_WRITE: c.char_code = 8'(arg_a);
      CMD_MOVE: begin
        c.move_dx = 8'(arg_a);
        c.move_dy = 8'(arg_b);
        // track the pointer so a read can land on it
        gen_px = fit(gen_px + arg_a, COLUMNS - 1);
        gen_py = fit(gen_py + arg_b, ROWS - 1);
      end
      CMD_READ: c.read_index = 11'(arg_a);
      default: ;
    endcase
    cmd_q.push_back(c);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 16'd1;

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      quiet_tail  <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        status_q.push_back(console_apply(cur_cmd));
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_if.valid <= 1'b0;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && n_accepted != n_results)) begin
          cur_cmd = cmd_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.cmd        <= cur_cmd.cmd;
          in_if.char_code  <= cur_cmd.char_code;
          in_if.move_dx    <= cur_cmd.move_dx;
          in_if.move_dy    <= cur_cmd.move_dy;
          in_if.read_index <= cur_cmd.read_index;
          if (!quiet_tail && !cyc[6] && $urandom_range(0, 3) == 0)
            gap_cnt = $urandom_range(1, 7);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      quiet_tail <= (cmd_q.size() < 40);
    end
  end

  // status monitor
  always @(posedge clk_i or negedge rst_ni) begin
    console_status_t got;
    console_status_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_results <= n_results + 1;
        got = {out_if.cursor_column, out_if.cursor_line, out_if.pointer_column,
               out_if.pointer_line, out_if.cell_data, out_if.screen_cleared};
        if (status_q.size() == 0) begin
          if (n_errors < 10)
            $display("unexpected status transaction: cursor %0d,%0d pointer %0d,%0d cell %h",
                     got.cur_col, got.cur_row, got.ptr_col, got.ptr_row, got.cell_word);
          n_errors++;
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            if (n_errors < 10)
              $display("status mismatch: exp cursor %0d,%0d ptr %0d,%0d cell %h clr %0b %s",
                       want.cur_col, want.cur_row, want.ptr_col, want.ptr_row,
                       want.cell_word, want.cleared,
                       $sformatf("got cursor %0d,%0d ptr %0d,%0d cell %h clr %0b",
                                 got.cur_col, got.cur_row, got.ptr_col, got.ptr_row,
                                 got.cell_word, got.cleared));
            n_errors++;
          end
        end
      end
      if (stall_cnt > 0)
        stall_cnt--;
      else if (!quiet_tail && !cyc[7] && $urandom_range(0, 3) == 0)
        stall_cnt = $urandom_range(1, 7);
      out_if.ready <= !hold_out && (stall_cnt == 0);
    end
  end

  // long output stall so the console backs up and stalls its input
  initial begin
    wait (n_accepted >= 150);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int         i;
    int         pick;
    int         len;
    bit         mid_drain;
    logic [7:0] ch;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_NONE;
    in_if.char_code  = '0;
    in_if.move_dx    = '0;
    in_if.move_dy    = '0;
    in_if.read_index = '0;
    out_if.ready     = 1'b0;
    mid_drain        = 1'b0;

    for (i = 0; i < CELLS; i++) screen[i] = {ATTR_BLANK, CHAR_SPACE};
    txt_col = 0;
    txt_row = 0;
    ptr_x   = PTR_COL_HOME;
    ptr_y   = PTR_ROW_HOME;
    invert_cell(ptr_y * COLUMNS + ptr_x);

    // directed: reset screen, edge characters, clamps, out-of-range reads
    queue_cmd(CMD_READ, PTR_ROW_HOME * COLUMNS + PTR_COL_HOME, 0);
    queue_cmd(CMD_READ, 0, 0);
    queue_cmd(CMD_READ, CELLS, 0);
    queue_cmd(CMD_READ, 2047, 0);
    queue_cmd(CMD_WRITE, 8'h00, 0);
    queue_cmd(CMD_WRITE, 8'hFF, 0);
    queue_cmd(CMD_WRITE, 8'h41, 0);
    queue_cmd(CMD_WRITE, CHAR_NEWLINE, 0);
    queue_cmd(CMD_READ, 0, 0);
    queue_cmd(CMD_READ, 1, 0);
    queue_cmd(CMD_READ, 2, 0);
    queue_cmd(CMD_NONE, 0, 0);
    queue_cmd(CMD_MOVE, 127, 127);
    queue_cmd(CMD_READ, CELLS - 1, 0);
    queue_cmd(CMD_MOVE, -128, -128);
    queue_cmd(CMD_READ, 0, 0);
    queue_cmd(CMD_MOVE, 1, 0);
    queue_cmd(CMD_READ, 0, 0);
    queue_cmd(CMD_READ, 1, 0);
    queue_cmd(CMD_MOVE, 0, 0);
    queue_cmd(CMD_WRITE, 8'h7E, 0);
    queue_cmd(CMD_READ, COLUMNS, 0);

    // hold the first random command until the console has drained
    drain_next = 1'b1;
    while (cmd_q.size() < 450) begin
      if (cmd_q.size() >= 300 && !mid_drain) begin
        drain_next = 1'b1;
        mid_drain  = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // text run, long enough at times to wrap the line
        len = $urandom_range(1, 90);
        repeat (len) begin
          ch = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 15) == 0) ch = CHAR_NEWLINE;
          queue_cmd(CMD_WRITE, ch, 0);
        end
      end else if (pick < 48) begin
        repeat ($urandom_range(1, 26)) queue_cmd(CMD_WRITE, CHAR_NEWLINE, 0);
      end else if (pick < 68) begin
        if ($urandom_range(0, 3) == 0)
          queue_cmd(CMD_MOVE, int'($urandom_range(0, 255)) - 128,
                    int'($urandom_range(0, 255)) - 128);
        else
          queue_cmd(CMD_MOVE, int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 6)) - 3);
        queue_cmd(CMD_READ, gen_py * COLUMNS + gen_px, 0);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0)
            queue_cmd(CMD_READ, $urandom_range(0, 2047), 0);
          else
            queue_cmd(CMD_READ, $urandom_range(0, 6 * COLUMNS - 1), 0);
        end
      end else begin
        queue_cmd(CMD_NONE, 0, 0);
      end
    end
    n_total = cmd_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_accepted >= n_total);
    wait (n_results >= n_total);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0 && status_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[text_console_with_pointer.f]
rtl/tcp_pkg.sv
rtl/tcp_if.sv
rtl/tcp_ram.sv
rtl/text_console_with_pointer.sv
tb/tb_text_console_with_pointer.sv
